@@ hdl/dapt_pkg.sv @@
// ============================================================================
// dapt_pkg - shared types, constants and helpers of the position tracker
// Widths of the item fields, the per-object state record, the control
// bundle handed to the axis lanes, and the saturation helpers.
// ============================================================================
package dapt_pkg;

    // Field widths
    localparam int IDX_W   = 6;     // object index
    localparam int TGT_W   = 16;    // target, whole pixels
    localparam int PIX_W   = 16;    // reported position, whole pixels
    localparam int GAIN_W  = 16;    // Q7.8 gains
    localparam int POS_W   = 24;    // Q15.8 position, error, drive
    localparam int INT_W   = 32;    // error integral
    localparam int DER_W   = 25;    // derivative, unsaturated
    localparam int FRAC_W  = 8;     // fraction bits of Q15.8
    localparam int WIDE_W  = 42;    // widest value handed to sat_pos
    localparam int SUM_W   = 50;    // sum of the three products

    localparam int OBJECTS_DEF = 64;

    // Stream widths
    localparam int IN_W  = 40;      // 38 bits of fields, padded to bytes
    localparam int OUT_W = 80;

    // Result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int CNT_W      = 4;

    // Configuration register indexes
    localparam int CFG_AW = 2;
    localparam logic [CFG_AW-1:0] REG_KP         = 2'd0;
    localparam logic [CFG_AW-1:0] REG_KI_DT      = 2'd1;
    localparam logic [CFG_AW-1:0] REG_KD_OVER_DT = 2'd2;

    // One object's state for one axis
    typedef struct packed {
        logic signed [POS_W-1:0] pos;
        logic signed [INT_W-1:0] integ;
        logic signed [POS_W-1:0] last_err;
    } state_t;

    // Memory control shared by both lanes
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             clr;
    } ctrl_t;

    // Saturate a wide signed value to the 24-bit Q15.8 range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WIDE_W-1:0] v);
        logic in_range;
        in_range = (&v[WIDE_W-1:POS_W-1]) || !(|v[WIDE_W-1:POS_W-1]);
        if (in_range)
            return v[POS_W-1:0];
        else if (v[WIDE_W-1])
            return {1'b1, {(POS_W-1){1'b0}}};
        else
            return {1'b0, {(POS_W-1){1'b1}}};
    endfunction

    // Saturate a 33-bit sum to the 32-bit integral range
    function automatic logic signed [INT_W-1:0] sat_int(input logic signed [INT_W:0] v);
        if (v[INT_W] == v[INT_W-1])
            return v[INT_W-1:0];
        else if (v[INT_W])
            return {1'b1, {(INT_W-1){1'b0}}};
        else
            return {1'b0, {(INT_W-1){1'b1}}};
    endfunction

    // Q15.8 to whole pixels, truncated toward zero
    function automatic logic signed [PIX_W-1:0] to_pixel(input logic signed [POS_W-1:0] p);
        logic [POS_W-1:0] adj;
        adj = p + {{(POS_W-FRAC_W){1'b0}}, {FRAC_W{p[POS_W-1]}}};
        return adj[POS_W-1:FRAC_W];
    endfunction

endpackage

@@ hdl/dapt_lane.sv @@
// ============================================================================
// dapt_lane - one axis of the PID tracker
// Holds the per-object state of one axis and runs the PID step as a
// five-stage pipeline: read, error, products, drive, position write-back.
// ============================================================================
module dapt_lane #(
    parameter int DEPTH = dapt_pkg::OBJECTS_DEF
) (
    input  logic                                 clk,
    input  dapt_pkg::ctrl_t                      ctrl,
    input  logic signed [dapt_pkg::TGT_W-1:0]    target,
    input  logic signed [dapt_pkg::GAIN_W-1:0]   kp,
    input  logic signed [dapt_pkg::GAIN_W-1:0]   ki_dt,
    input  logic signed [dapt_pkg::GAIN_W-1:0]   kd_over_dt,
    output logic signed [dapt_pkg::POS_W-1:0]    pos,
    output logic signed [dapt_pkg::POS_W-1:0]    drive
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    dapt_pkg::state_t mem [DEPTH];
    dapt_pkg::state_t rd_reg;
    dapt_pkg::state_t wr_data;

    logic signed [dapt_pkg::TGT_W-1:0] tgt_reg;

    // Error stage
    logic signed [dapt_pkg::POS_W-1:0] tgt_q;
    logic signed [dapt_pkg::POS_W:0]   diff;
    logic signed [dapt_pkg::POS_W-1:0] err_next;
    logic signed [dapt_pkg::INT_W:0]   integ_sum;
    logic signed [dapt_pkg::INT_W-1:0] integ_next;
    logic signed [dapt_pkg::DER_W-1:0] deriv_next;

    logic signed [dapt_pkg::POS_W-1:0] err1_reg;
    logic signed [dapt_pkg::INT_W-1:0] integ1_reg;
    logic signed [dapt_pkg::DER_W-1:0] deriv1_reg;
    logic signed [dapt_pkg::POS_W-1:0] pos1_reg;

    // Product stage
    logic signed [dapt_pkg::GAIN_W+dapt_pkg::POS_W-1:0] p_kp_reg;
    logic signed [dapt_pkg::GAIN_W+dapt_pkg::INT_W-1:0] p_ki_reg;
    logic signed [dapt_pkg::GAIN_W+dapt_pkg::DER_W-1:0] p_kd_reg;
    logic signed [dapt_pkg::POS_W-1:0] err2_reg;
    logic signed [dapt_pkg::INT_W-1:0] integ2_reg;
    logic signed [dapt_pkg::POS_W-1:0] pos2_reg;

    // Drive stage
    logic signed [dapt_pkg::SUM_W-1:0] sum;
    logic signed [dapt_pkg::POS_W-1:0] drive_next;
    logic signed [dapt_pkg::POS_W-1:0] drive3_reg;
    logic signed [dapt_pkg::POS_W-1:0] err3_reg;
    logic signed [dapt_pkg::INT_W-1:0] integ3_reg;
    logic signed [dapt_pkg::POS_W-1:0] pos3_reg;

    // Write-back stage
    logic signed [dapt_pkg::POS_W:0]   pos_sum;
    logic signed [dapt_pkg::POS_W-1:0] pos_next;
    logic signed [dapt_pkg::POS_W-1:0] pos_reg;
    logic signed [dapt_pkg::POS_W-1:0] drive_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_reg <= mem[ctrl.rd_addr[ADDR_W-1:0]];
        end
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_addr[ADDR_W-1:0]] <= wr_data;
        end
    end

    always_comb
    begin
        tgt_q      = {tgt_reg, {dapt_pkg::FRAC_W{1'b0}}};
        diff       = (dapt_pkg::POS_W+1)'(tgt_q) - (dapt_pkg::POS_W+1)'(rd_reg.pos);
        err_next   = dapt_pkg::sat_pos(dapt_pkg::WIDE_W'(diff));
        integ_sum  = (dapt_pkg::INT_W+1)'(rd_reg.integ) + (dapt_pkg::INT_W+1)'(err_next);
        integ_next = dapt_pkg::sat_int(integ_sum);
        deriv_next = dapt_pkg::DER_W'(err_next) - dapt_pkg::DER_W'(rd_reg.last_err);
    end

    always_comb
    begin
        sum = dapt_pkg::SUM_W'(p_kp_reg) + dapt_pkg::SUM_W'(p_ki_reg)
            + dapt_pkg::SUM_W'(p_kd_reg);
        // arithmetic shift by the fraction bits rounds toward minus infinity
        drive_next = dapt_pkg::sat_pos(sum[dapt_pkg::SUM_W-1:dapt_pkg::FRAC_W]);
        pos_sum    = (dapt_pkg::POS_W+1)'(pos3_reg) + (dapt_pkg::POS_W+1)'(drive3_reg);
        pos_next   = dapt_pkg::sat_pos(dapt_pkg::WIDE_W'(pos_sum));
        if (ctrl.clr)
        begin
            wr_data = '0;
        end
        else
        begin
            wr_data = '{pos: pos_next, integ: integ3_reg, last_err: err3_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        tgt_reg    <= target;

        err1_reg   <= err_next;
        integ1_reg <= integ_next;
        deriv1_reg <= deriv_next;
        pos1_reg   <= rd_reg.pos;

        p_kp_reg   <= kp * err1_reg;
        p_ki_reg   <= ki_dt * integ1_reg;
        p_kd_reg   <= kd_over_dt * deriv1_reg;
        err2_reg   <= err1_reg;
        integ2_reg <= integ1_reg;
        pos2_reg   <= pos1_reg;

        drive3_reg <= drive_next;
        err3_reg   <= err2_reg;
        integ3_reg <= integ2_reg;
        pos3_reg   <= pos2_reg;

        pos_reg    <= pos_next;
        drive_reg  <= drive3_reg;
    end

    assign pos   = pos_reg;
    assign drive = drive_reg;

endmodule

@@ hdl/dapt_merge.sv @@
// ============================================================================
// dapt_merge - joins the two axis results into one output transaction
// Converts positions to whole pixels and queues the packed result for the
// output stream.
// ============================================================================
module dapt_merge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  logic signed [dapt_pkg::POS_W-1:0]   pos_x,
    input  logic signed [dapt_pkg::POS_W-1:0]   pos_y,
    input  logic signed [dapt_pkg::POS_W-1:0]   drive_x,
    input  logic signed [dapt_pkg::POS_W-1:0]   drive_y,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [dapt_pkg::OUT_W-1:0]          m_axis_tdata
);

    logic [dapt_pkg::OUT_W-1:0]   fifo_reg [dapt_pkg::FIFO_DEPTH];
    logic [dapt_pkg::FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [dapt_pkg::FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [dapt_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [dapt_pkg::OUT_W-1:0]   entry;
    logic                         pop;

    assign entry = {drive_y, drive_x, dapt_pkg::to_pixel(pos_y), dapt_pkg::to_pixel(pos_x)};
    assign pop   = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + dapt_pkg::CNT_W'(push) - dapt_pkg::CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= entry;
        end
    end

    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tdata  = fifo_reg[rd_ptr_reg];

endmodule

@@ hdl/dual_axis_pid_position_tracker.sv @@
// ============================================================================
// dual_axis_pid_position_tracker - two-axis fixed-point PID position tracker
// Steps the X and Y PID controllers of one tracked object per transaction
// and reports the new whole-pixel position and the drive of each axis.
// ============================================================================
//
//  Channel   Direction  Handshake                Contents
//  s_axis    in         tvalid/tready            object index, X and Y target
//  m_axis    out        tvalid/tready            X/Y position, X/Y drive
//  cfg       in         cfg_we (no wait)         kp, ki_dt, kd_over_dt
//
//  An input transaction passes the lane pipeline and the result queue on
//  its way to the output. One transaction per cycle is sustained while queue
//  credit remains and no transaction names an object still in the pipeline;
//  a transaction for such an object waits until its position has been
//  written back, since the position update closes a loop through the three
//  multipliers. After reset, a clearing pass zeroes the min(OBJECTS,64)
//  state memory entries one by one; s_axis_tready stays low during the pass.
//  An eight-entry result queue decouples the output: input is taken while
//  results wait, as long as queue credit remains.
// ============================================================================
module dual_axis_pid_position_tracker #(
    parameter int OBJECTS = dapt_pkg::OBJECTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [5:0] object_index, [21:6] goal_x, [37:22] goal_y, [39:38] zero
    input  logic [dapt_pkg::IN_W-1:0]        s_axis_tdata,

    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [15:0] pos_x, [31:16] pos_y, [55:32] drive_x, [79:56] drive_y
    output logic [dapt_pkg::OUT_W-1:0]       m_axis_tdata,

    input  logic                             cfg_we,
    input  logic [dapt_pkg::CFG_AW-1:0]      cfg_addr,
    input  logic [dapt_pkg::GAIN_W-1:0]      cfg_wdata
);

    // Only the low six index bits exist, so no more than 64 entries are used.
    localparam int IDX_SPAN = 2 ** dapt_pkg::IDX_W;
    localparam int DEPTH    = (OBJECTS < IDX_SPAN) ? OBJECTS : IDX_SPAN;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [dapt_pkg::GAIN_W-1:0] kp_reg, ki_dt_reg, kd_over_dt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg         <= '0;
            ki_dt_reg      <= '0;
            kd_over_dt_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                dapt_pkg::REG_KP:         kp_reg         <= cfg_wdata;
                dapt_pkg::REG_KI_DT:      ki_dt_reg      <= cfg_wdata;
                dapt_pkg::REG_KD_OVER_DT: kd_over_dt_reg <= cfg_wdata;
                default:                  ;   // drop writes past the list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Index reduction: constant table of index modulo the object count
    // ------------------------------------------------------------------
    logic [dapt_pkg::IDX_W-1:0] mod_tab [IDX_SPAN];
    logic [dapt_pkg::IDX_W-1:0] in_addr;

    for (genvar g = 0; g < IDX_SPAN; g++)
    begin : g_mod
        assign mod_tab[g] = dapt_pkg::IDX_W'(g % DEPTH);
    end

    assign in_addr = mod_tab[s_axis_tdata[dapt_pkg::IDX_W-1:0]];

    // ------------------------------------------------------------------
    // Clearing pass after reset
    // ------------------------------------------------------------------
    logic                       clr_active_reg, clr_active_next;
    logic [dapt_pkg::IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic                       clr_last;

    assign clr_last = (clr_cnt_reg == dapt_pkg::IDX_W'(DEPTH - 1));

    always_comb
    begin
        clr_active_next = clr_active_reg && !clr_last;
        clr_cnt_next    = clr_active_reg ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_cnt_reg    <= clr_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline tracking: valid bits for five stages, addresses for the
    // four stages whose write-back is still pending
    // ------------------------------------------------------------------
    logic [4:0]                 vld_reg, vld_next;
    logic [dapt_pkg::IDX_W-1:0] addr_reg [4];
    logic [3:0]                 hit;
    logic                       hazard;
    logic                       in_fire;
    logic                       pop;
    logic [dapt_pkg::CNT_W-1:0] credit_reg, credit_next;

    for (genvar s = 0; s < 4; s++)
    begin : g_hit
        assign hit[s] = vld_reg[s] && (addr_reg[s] == in_addr);
    end

    assign hazard        = |hit;
    assign s_axis_tready = !clr_active_reg && !hazard
                           && (credit_reg < dapt_pkg::CNT_W'(dapt_pkg::FIFO_DEPTH));
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign pop           = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        vld_next    = {vld_reg[3:0], in_fire};
        credit_next = credit_reg + dapt_pkg::CNT_W'(in_fire) - dapt_pkg::CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            credit_reg <= '0;
        end
        else
        begin
            vld_reg    <= vld_next;
            credit_reg <= credit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg[0] <= in_addr;
        addr_reg[1] <= addr_reg[0];
        addr_reg[2] <= addr_reg[1];
        addr_reg[3] <= addr_reg[2];
    end

    // Memory control for both lanes; clearing and write-back never overlap
    dapt_pkg::ctrl_t ctrl;

    always_comb
    begin
        ctrl.rd_en   = in_fire;
        ctrl.rd_addr = in_addr;
        ctrl.clr     = clr_active_reg;
        ctrl.wr_en   = clr_active_reg || vld_reg[3];
        ctrl.wr_addr = clr_active_reg ? clr_cnt_reg : addr_reg[3];
    end

    // ------------------------------------------------------------------
    // Axis lanes
    // ------------------------------------------------------------------
    logic signed [dapt_pkg::POS_W-1:0] pos_x, pos_y, drive_x, drive_y;

    dapt_lane #(
        .DEPTH (DEPTH)
    ) u_lane_x (
        .clk        (clk),
        .ctrl       (ctrl),
        .target     (s_axis_tdata[dapt_pkg::IDX_W +: dapt_pkg::TGT_W]),
        .kp         (kp_reg),
        .ki_dt      (ki_dt_reg),
        .kd_over_dt (kd_over_dt_reg),
        .pos        (pos_x),
        .drive      (drive_x)
    );

    dapt_lane #(
        .DEPTH (DEPTH)
    ) u_lane_y (
        .clk        (clk),
        .ctrl       (ctrl),
        .target     (s_axis_tdata[dapt_pkg::IDX_W + dapt_pkg::TGT_W +: dapt_pkg::TGT_W]),
        .kp         (kp_reg),
        .ki_dt      (ki_dt_reg),
        .kd_over_dt (kd_over_dt_reg),
        .pos        (pos_y),
        .drive      (drive_y)
    );

    // ------------------------------------------------------------------
    // Merge and result queue
    // ------------------------------------------------------------------
    dapt_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (vld_reg[4]),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .drive_x       (drive_x),
        .drive_y       (drive_y),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> !clr_active_reg)
        else $error("transaction accepted during clearing pass");

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= dapt_pkg::CNT_W'(dapt_pkg::FIFO_DEPTH))
        else $error("result queue credit overrun");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> ##5 vld_reg[4])
        else $error("accepted transaction did not reach the merge stage");

    a_output_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (credit_reg != '0))
        else $error("output valid without an outstanding transaction");

    a_clear_full_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clr_active_reg) |-> $past(clr_last))
        else $error("clearing pass ended early");

endmodule

@@ tb/pid_track_check_pkg.sv @@
`timescale 1ns / 100ps
// ============================================================================
// pid_track_check_pkg - result predictor for the position tracker bench
// Keeps its own copy of the per-object PID state and the gains, and works
// out the expected result of every accepted input transaction.
// ============================================================================
package pid_track_check_pkg;

    import dapt_pkg::*;

    localparam longint Q15_MAX = 64'sd8388607;
    localparam longint Q15_MIN = -64'sd8388608;
    localparam longint ACC_MAX = 64'sd2147483647;
    localparam longint ACC_MIN = -64'sd2147483648;

    // Same layout as m_axis_tdata, lowest field last
    typedef struct packed {
        logic signed [POS_W-1:0] drive_y;
        logic signed [POS_W-1:0] drive_x;
        logic signed [PIX_W-1:0] pos_y;
        logic signed [PIX_W-1:0] pos_x;
    } tracker_result_t;

    class tracker_scoreboard;
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        // axis 0 is X, axis 1 is Y
        logic signed [POS_W-1:0]  position   [2][OBJECTS_DEF];
        logic signed [INT_W-1:0]  integral   [2][OBJECTS_DEF];
        logic signed [POS_W-1:0]  prev_error [2][OBJECTS_DEF];
        tracker_result_t          awaited[$];
        int                       failures;

        function new();
            gain_p = '0;
            gain_i = '0;
            gain_d = '0;
            failures = 0;
            for (int a = 0; a < 2; a++)
            begin
                for (int o = 0; o < OBJECTS_DEF; o++)
                begin
                    position[a][o]   = '0;
                    integral[a][o]   = '0;
                    prev_error[a][o] = '0;
                end
            end
        endfunction

        function void set_gains(logic signed [GAIN_W-1:0] p, logic signed [GAIN_W-1:0] i,
                                logic signed [GAIN_W-1:0] d);
            gain_p = p;
            gain_i = i;
            gain_d = d;
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            if (v < lo)
                return lo;
            if (v > hi)
                return hi;
            return v;
        endfunction

        // One PID step of one axis; update the stored state, return the drive
        function logic signed [POS_W-1:0] advance_axis(int axis, int obj,
                                                       logic signed [TGT_W-1:0] target);
            longint err;
            longint acc;
            longint slope;
            longint sum;
            longint drv;
            longint pos;
            pos   = longint'(position[axis][obj]);
            err   = clamp((longint'(target) <<< FRAC_W) - pos, Q15_MIN, Q15_MAX);
            acc   = clamp(longint'(integral[axis][obj]) + err, ACC_MIN, ACC_MAX);
            slope = err - longint'(prev_error[axis][obj]);
            sum   = longint'(gain_p) * err + longint'(gain_i) * acc + longint'(gain_d) * slope;
            // arithmetic shift rounds toward minus infinity
            drv   = clamp(sum >>> FRAC_W, Q15_MIN, Q15_MAX);
            pos   = clamp(pos + drv, Q15_MIN, Q15_MAX);
            integral[axis][obj]   = INT_W'(acc);
            prev_error[axis][obj] = POS_W'(err);
            position[axis][obj]   = POS_W'(pos);
            return POS_W'(drv);
        endfunction

        function void note_item(logic [IDX_W-1:0] obj, logic signed [TGT_W-1:0] tx,
                                logic signed [TGT_W-1:0] ty);
            tracker_result_t r;
            r.drive_x = advance_axis(0, int'(obj) % OBJECTS_DEF, tx);
            r.drive_y = advance_axis(1, int'(obj) % OBJECTS_DEF, ty);
            // integer division truncates toward zero
            r.pos_x = PIX_W'(longint'(position[0][int'(obj) % OBJECTS_DEF]) / (1 << FRAC_W));
            r.pos_y = PIX_W'(longint'(position[1][int'(obj) % OBJECTS_DEF]) / (1 << FRAC_W));
            awaited.push_back(r);
        endfunction

        function void compare_field(string label, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
                failures++;
            end
        endfunction

        function void check_result(logic [OUT_W-1:0] data);
            tracker_result_t got;
            tracker_result_t want;
            got = data;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h", $time, data);
                failures++;
                return;
            end
            want = awaited.pop_front();
            compare_field("pos_x", 32'(want.pos_x), 32'(got.pos_x));
            compare_field("pos_y", 32'(want.pos_y), 32'(got.pos_y));
            compare_field("drive_x", 32'(want.drive_x), 32'(got.drive_x));
            compare_field("drive_y", 32'(want.drive_y), 32'(got.drive_y));
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

endpackage

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ============================================================================
// testbench - self-checking bench of the two-axis PID position tracker
// Runs directed steps over the gain and target extremes, an integrator
// windup, then random tracking phases under several gain settings while
// both stream sides idle at random; every result is checked field by field.
// ============================================================================
module testbench;

    import dapt_pkg::*;
    import pid_track_check_pkg::*;

    // Index past the end of the register list; the block must drop the write
    localparam logic [CFG_AW-1:0] REG_SPARE = 2'd3;

    localparam int         DRAIN_CYCLES = 12;      // pipeline depth plus margin
    localparam int         QUIET_LIMIT  = 2000;    // cycles with no transaction
    localparam int         HOLD_CYCLES  = 400;     // long receiver back-pressure
    localparam int         PHASE_ITEMS  = 120;
    localparam int         WINDUP_ITEMS = 260;
    localparam logic [IDX_W-1:0] WINDUP_OBJ = 6'd42;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    // [5:0] object_index, [21:6] goal_x, [37:22] goal_y, [39:38] zero
    logic [IN_W-1:0]    s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    // [15:0] pos_x, [31:16] pos_y, [55:32] drive_x, [79:56] drive_y
    logic [OUT_W-1:0]   m_axis_tdata;
    logic               cfg_we;
    logic [CFG_AW-1:0]  cfg_addr;
    logic [GAIN_W-1:0]  cfg_wdata;

    tracker_scoreboard  tracker = new();

    // Last target sent per object, so most random steps drift smoothly
    logic signed [TGT_W-1:0] aim_x [OBJECTS_DEF];
    logic signed [TGT_W-1:0] aim_y [OBJECTS_DEF];

    // Receiver back-pressure control
    bit  rx_hold_req;
    int  rx_hold_left;
    int  rx_gap_left;
    int  rx_calm_left;
    bit  rx_calm;
    int  quiet_cycles;

    dual_axis_pid_position_tracker uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Full-scale, zero or minus one, to hit the saturation corners
    function automatic logic signed [TGT_W-1:0] edge_target();
        case ($urandom_range(0, 3))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            default: return 16'shFFFF;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random ready with calm stretches, plus one long hold-off
    // that the stimulus requests to fill the block up.
    // ------------------------------------------------------------------
    initial
    begin
        m_axis_tready <= 1'b0;
        rx_hold_left = 0;
        rx_gap_left  = 0;
        rx_calm_left = 0;
        rx_calm      = 1'b1;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req  = 1'b0;
                rx_hold_left = HOLD_CYCLES;
            end
            if (rx_calm_left == 0)
            begin
                rx_calm      = ($urandom_range(0, 2) == 0);
                rx_calm_left = $urandom_range(50, 300);
            end
            else
                rx_calm_left--;

            if (rx_hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_hold_left--;
            end
            else if (rx_gap_left > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_gap_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!rx_calm)
                    rx_gap_left = pick_pause();
            end
        end
    end

    // Check every output transaction against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_result(m_axis_tdata);
    end

    // Watchdog: end the run if no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one item, hold it until accepted, then idle for the given gap
    task automatic send_target(input logic [IDX_W-1:0] obj, input logic signed [TGT_W-1:0] tx,
                               input logic signed [TGT_W-1:0] ty, input int gap);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, ty, tx, obj};
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.note_item(obj, tx, ty);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid, wait for every result, then let the pipeline settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all three gains back to back; optionally poke the spare index
    task automatic program_gains(input logic signed [GAIN_W-1:0] p,
                                 input logic signed [GAIN_W-1:0] i,
                                 input logic signed [GAIN_W-1:0] d, input bit poke_spare);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_KP;
        cfg_wdata <= p;
        @(posedge clk);
        cfg_addr  <= REG_KI_DT;
        cfg_wdata <= i;
        @(posedge clk);
        cfg_addr  <= REG_KD_OVER_DT;
        cfg_wdata <= d;
        @(posedge clk);
        if (poke_spare)
        begin
            cfg_addr  <= REG_SPARE;
            cfg_wdata <= 16'($urandom);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        tracker.set_gains(p, i, d);
    endtask

    // ------------------------------------------------------------------
    // Random tracking: bursts over a small crew of objects so the same
    // object often comes back while still in flight. Most steps drift the
    // target a little; the rest jump, hit the extremes or pick any object.
    // squeeze asks the receiver for one long hold-off mid-phase while the
    // sender keeps offering; every phase pauses once until fully drained.
    // ------------------------------------------------------------------
    task automatic run_tracking_phase(input int n_items, input bit squeeze);
        int                      sent;
        int                      burst_len;
        int                      crew_n;
        int                      k;
        int                      r;
        bit                      gapless;
        bit                      squeezed;
        bit                      paused;
        logic [IDX_W-1:0]        crew [4];
        logic [IDX_W-1:0]        obj;
        logic signed [TGT_W-1:0] tx;
        logic signed [TGT_W-1:0] ty;
        sent     = 0;
        squeezed = 1'b0;
        paused   = 1'b0;
        while (sent < n_items)
        begin
            burst_len = $urandom_range(8, 30);
            gapless   = ($urandom_range(0, 2) == 0);
            crew_n    = $urandom_range(1, 4);
            for (k = 0; k < 4; k++)
                crew[k] = ($urandom_range(0, 9) == 0) ? WINDUP_OBJ : 6'($urandom_range(0, 63));
            if (squeeze && !squeezed && sent >= n_items / 3)
            begin
                squeezed    = 1'b1;
                rx_hold_req = 1'b1;
                gapless     = 1'b1;
                burst_len   = 40;
            end
            if (!paused && sent >= (2 * n_items) / 3)
            begin
                paused = 1'b1;
                wait_drained();
            end
            for (k = 0; k < burst_len && sent < n_items; k++)
            begin
                obj = crew[$urandom_range(0, crew_n - 1)];
                r   = $urandom_range(0, 99);
                if (r < 60)
                begin
                    tx = aim_x[obj] + 16'($urandom_range(0, 64)) - 16'd32;
                    ty = aim_y[obj] + 16'($urandom_range(0, 64)) - 16'd32;
                end
                else if (r < 85)
                begin
                    tx = 16'($urandom);
                    ty = 16'($urandom);
                end
                else if (r < 95)
                begin
                    tx = edge_target();
                    ty = edge_target();
                end
                else
                begin
                    obj = 6'($urandom);
                    tx  = 16'($urandom);
                    ty  = 16'($urandom);
                end
                aim_x[obj] = tx;
                aim_y[obj] = ty;
                send_target(obj, tx, ty, gapless ? 0 : pick_pause());
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_we        <= 1'b0;
        cfg_addr      <= REG_KP;
        cfg_wdata     <= '0;
        rx_hold_req    = 1'b0;
        for (int o = 0; o < OBJECTS_DEF; o++)
        begin
            aim_x[o] = '0;
            aim_y[o] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Gains at reset value: drive stays zero, positions stay put
        send_target(6'd0, 16'sd0, 16'sd0, 0);
        send_target(6'd63, 16'sh7FFF, 16'sh8000, 2);
        wait_drained();

        // Unit proportional gain; the spare register index must be ignored
        program_gains(16'sh0100, 16'sh0000, 16'sh0000, 1'b1);
        send_target(6'd1, 16'sd100, -16'sd100, 0);
        send_target(6'd1, 16'sd100, -16'sd100, 0);
        send_target(6'd2, 16'sh7FFF, 16'sh8000, 1);
        wait_drained();

        // Extreme gains: drive and position saturate, error saturates when
        // the target jumps across the full range, and a negative position
        // with a fraction truncates toward zero in the reported pixel
        program_gains(16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b0);
        send_target(6'd3, 16'sd1, -16'sd1, 0);
        send_target(6'd3, 16'sd0, 16'sd0, 0);
        send_target(6'd2, 16'sh8000, 16'sh7FFF, 1);
        send_target(6'd2, 16'sh8000, 16'sh7FFF, 0);
        send_target(6'd2, 16'sh7FFF, 16'sh8000, 0);
        send_target(6'd63, 16'sd0, 16'sd0, 3);
        wait_drained();

        // Small fractional gains: the drive rounds toward minus infinity
        program_gains(16'sd85, -16'sd1, 16'sd1, 1'b0);
        send_target(6'd10, 16'sd1, -16'sd1, 0);
        send_target(6'd10, -16'sd1, 16'sd1, 0);
        send_target(6'd10, 16'sd3, -16'sd3, 2);
        send_target(6'd11, -16'sd200, 16'sd200, 0);
        wait_drained();

        // Windup: zero gains hold the position, so a full-scale error
        // drives the integral into saturation on both sides
        program_gains(16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
        for (int n = 0; n < WINDUP_ITEMS; n++)
            send_target(WINDUP_OBJ, 16'sh7FFF, 16'sh8000, ($urandom_range(0, 3) == 0) ? 1 : 0);
        aim_x[WINDUP_OBJ] = 16'sh7FFF;
        aim_y[WINDUP_OBJ] = 16'sh8000;

        for (int phase = 0; phase < 5; phase++)
        begin
            wait_drained();
            case (phase)
                0:       program_gains(16'sh0100, 16'sh0001, 16'sh0040, 1'b0);
                1:       program_gains(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
                2:       program_gains(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
                3:       program_gains(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
                default: program_gains(16'($urandom_range(0, 1023)) - 16'sd512,
                                       16'($urandom_range(0, 63)) - 16'sd32,
                                       16'($urandom_range(0, 1023)) - 16'sd512, 1'b0);
            endcase
            run_tracking_phase(PHASE_ITEMS, phase == 1);
        end

        wait_drained();
        if (tracker.failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
